[hdl/macx_pkg.sv]
// Shared constants for the moving average crossover trader.
package macx_pkg;

    // Default depth of the price history.
    localparam int MAX_WINDOW_DEF = 64;

    // Fixed field widths.
    localparam int PRICE_W  = 32;
    localparam int PROFIT_W = 48;
    localparam int WCFG_W   = 7;
    localparam int ACT_W    = 2;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // Output tdata width: fields rounded up to whole bytes.
    localparam int OUT_FIELDS_W = ACT_W + PRICE_W + PROFIT_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Trade decision codes.
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BUY  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SELL = 2'd2;

    // Register indexes, decoded from the word address bit.
    localparam logic REG_SHORT = 1'b0;
    localparam logic REG_LONG  = 1'b1;

    // Register reset values.
    localparam logic [WCFG_W-1:0] SHORT_RST = 7'd3;
    localparam logic [WCFG_W-1:0] LONG_RST  = 7'd5;

endpackage

[hdl/moving_average_crossover_trader.sv]
// Stage 1 (sums), 2 (products), 3 (decision), then the output register; one price per cycle
// while m_tready does not stall it; the history memory has two read ports for the prices
// leaving both windows and one write port for the new price, all used in the accept cycle.
// Reset (aresetn, synchronous, active low): windows 3 and 5, both windows empty, no position,
// zero profit, pipeline empty. The history memory is not cleared; the fill count guards reads.
module moving_average_crossover_trader
    import macx_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Price stream in.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PRICE_W-1:0]     s_tdata,   // [31:0] price
    // Result stream out.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [1:0] action, [33:2] trade_price, [81:34] total_profit, [82] windows_full, rest zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // Configuration port.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    localparam int AW     = $clog2(MAX_WINDOW);
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int IW     = WIN_W + 1;
    localparam int SUM_W  = PRICE_W + AW;
    localparam int PROD_W = SUM_W + WIN_W;
    localparam int PEXT_W = PROFIT_W + 2;

    localparam logic signed [PEXT_W-1:0] PROFIT_MAX =
        PEXT_W'((64'sd1 <<< (PROFIT_W - 1)) - 64'sd1);
    localparam logic signed [PEXT_W-1:0] PROFIT_MIN =
        PEXT_W'(-(64'sd1 <<< (PROFIT_W - 1)));

    // Configuration registers.
    logic [WCFG_W-1:0] short_win_reg;
    logic [WCFG_W-1:0] long_win_reg;
    logic              cfg_wr;

    // Window state.
    logic [AW-1:0]     wp_reg;
    logic [WIN_W-1:0]  fill_reg;
    logic [SUM_W-1:0]  short_sum_reg;
    logic [SUM_W-1:0]  long_sum_reg;

    // Position state.
    logic                       holding_reg;
    logic [PRICE_W-1:0]         entry_reg;
    logic signed [PROFIT_W-1:0] profit_reg;

    // History memory and its read data.
    logic [PRICE_W-1:0] hist_mem [MAX_WINDOW];
    logic [PRICE_W-1:0] rd_short_reg;
    logic [PRICE_W-1:0] rd_long_reg;

    // Stage 1: sums.
    logic               v1_reg;
    logic [PRICE_W-1:0] price1_reg;
    logic               sub_s1_reg;
    logic               sub_l1_reg;
    logic               full1_reg;

    // Stage 2: products.
    logic               v2_reg;
    logic [PRICE_W-1:0] price2_reg;
    logic               full2_reg;
    logic [SUM_W-1:0]   ssum2_reg;
    logic [SUM_W-1:0]   lsum2_reg;

    // Stage 3: decision.
    logic               v3_reg;
    logic [PRICE_W-1:0] price3_reg;
    logic               full3_reg;
    logic [PROD_W-1:0]  lhs3_reg;
    logic [PROD_W-1:0]  rhs3_reg;

    // Output register.
    logic                       m_tvalid_reg;
    logic [ACT_W-1:0]           act_reg;
    logic [PRICE_W-1:0]         tprice_reg;
    logic signed [PROFIT_W-1:0] oprofit_reg;
    logic                       ofull_reg;

    // Effective windows, clamped to 1..MAX_WINDOW.
    logic [WIN_W-1:0] s_eff;
    logic [WIN_W-1:0] l_eff;
    logic [WIN_W-1:0] need;

    always_comb begin
        if (short_win_reg == '0) begin
            s_eff = WIN_W'(1);
        end else if (32'(short_win_reg) > 32'(MAX_WINDOW)) begin
            s_eff = WIN_W'(MAX_WINDOW);
        end else begin
            s_eff = WIN_W'(short_win_reg);
        end
        if (long_win_reg == '0) begin
            l_eff = WIN_W'(1);
        end else if (32'(long_win_reg) > 32'(MAX_WINDOW)) begin
            l_eff = WIN_W'(MAX_WINDOW);
        end else begin
            l_eff = WIN_W'(long_win_reg);
        end
        need = (s_eff > l_eff) ? s_eff : l_eff;
    end

    // Handshake chain: each stage moves when the one after it has room.
    logic ready_out, ready3, ready2, ready1;
    logic accept, move1, move2, move3;

    assign ready_out = !m_tvalid_reg || m_tready;
    assign ready3    = !v3_reg || ready_out;
    assign ready2    = !v2_reg || ready3;
    assign ready1    = !v1_reg || ready2;
    assign s_tready  = ready1;
    assign accept    = s_tvalid && ready1;
    assign move1     = v1_reg && ready2;
    assign move2     = v2_reg && ready3;
    assign move3     = v3_reg && ready_out;

    // Configuration port: writes in the access phase, reads return the stored window.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_SHORT: prdata = DATA_W'(short_win_reg);
            REG_LONG:  prdata = DATA_W'(long_win_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_win_reg <= SHORT_RST;
            long_win_reg  <= LONG_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_SHORT: short_win_reg <= pwdata[WCFG_W-1:0];
                REG_LONG:  long_win_reg  <= pwdata[WCFG_W-1:0];
                default:   short_win_reg <= short_win_reg;
            endcase
        end
    end

    // Ring addresses of the prices that leave each window.
    logic [IW-1:0]    idx_s_raw, idx_l_raw;
    logic [AW-1:0]    idx_s, idx_l;
    logic [AW-1:0]    wp_next;
    logic [WIN_W-1:0] fill_next;

    always_comb begin
        idx_s_raw = IW'(wp_reg) + IW'(MAX_WINDOW) - IW'(s_eff);
        idx_l_raw = IW'(wp_reg) + IW'(MAX_WINDOW) - IW'(l_eff);
        if (idx_s_raw >= IW'(MAX_WINDOW)) begin
            idx_s_raw = idx_s_raw - IW'(MAX_WINDOW);
        end
        if (idx_l_raw >= IW'(MAX_WINDOW)) begin
            idx_l_raw = idx_l_raw - IW'(MAX_WINDOW);
        end
        idx_s = idx_s_raw[AW-1:0];
        idx_l = idx_l_raw[AW-1:0];
        wp_next = (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : wp_reg + AW'(1);
        fill_next = (fill_reg < WIN_W'(MAX_WINDOW)) ? fill_reg + WIN_W'(1) : fill_reg;
    end

    // History memory: the new price is written as both leaving prices are read.
    // A read of the entry being overwritten returns the old price.
    always_ff @(posedge aclk) begin
        if (accept) begin
            hist_mem[wp_reg] <= s_tdata;
            rd_short_reg     <= hist_mem[idx_s];
            rd_long_reg      <= hist_mem[idx_l];
        end
    end

    // Running sums with the leaving prices dropped.
    logic [SUM_W-1:0] short_sum_next, long_sum_next;

    always_comb begin
        short_sum_next = short_sum_reg + SUM_W'(price1_reg);
        long_sum_next  = long_sum_reg + SUM_W'(price1_reg);
        if (sub_s1_reg) begin
            short_sum_next = short_sum_next - SUM_W'(rd_short_reg);
        end
        if (sub_l1_reg) begin
            long_sum_next = long_sum_next - SUM_W'(rd_long_reg);
        end
    end

    // Window state: pointer, fill count and sums; a register write empties both windows.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            short_sum_reg <= '0;
            long_sum_reg  <= '0;
        end else if (cfg_wr) begin
            fill_reg      <= '0;
            short_sum_reg <= '0;
            long_sum_reg  <= '0;
        end else begin
            if (accept) begin
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
            end
            if (move1) begin
                short_sum_reg <= short_sum_next;
                long_sum_reg  <= long_sum_next;
            end
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= accept;
            end
            if (ready2) begin
                v2_reg <= move1;
            end
            if (ready3) begin
                v3_reg <= move2;
            end
            if (ready_out) begin
                m_tvalid_reg <= move3;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (accept) begin
            price1_reg <= s_tdata;
            sub_s1_reg <= fill_reg >= s_eff;
            sub_l1_reg <= fill_reg >= l_eff;
            full1_reg  <= fill_next >= need;
        end
        if (move1) begin
            price2_reg <= price1_reg;
            full2_reg  <= full1_reg;
            ssum2_reg  <= short_sum_next;
            lsum2_reg  <= long_sum_next;
        end
        if (move2) begin
            price3_reg <= price2_reg;
            full3_reg  <= full2_reg;
            lhs3_reg   <= PROD_W'(ssum2_reg) * PROD_W'(l_eff);
            rhs3_reg   <= PROD_W'(lsum2_reg) * PROD_W'(s_eff);
        end
    end

    // Trade decision and saturating profit.
    logic signed [PEXT_W-1:0]   profit_sum;
    logic signed [PROFIT_W-1:0] profit_next;
    logic                       buy, sell;

    always_comb begin
        profit_sum = PEXT_W'(profit_reg)
                   + $signed(PEXT_W'(price3_reg))
                   - $signed(PEXT_W'(entry_reg));
        priority if (profit_sum > PROFIT_MAX) begin
            profit_next = PROFIT_MAX[PROFIT_W-1:0];
        end else if (profit_sum < PROFIT_MIN) begin
            profit_next = PROFIT_MIN[PROFIT_W-1:0];
        end else begin
            profit_next = profit_sum[PROFIT_W-1:0];
        end
        buy  = full3_reg && (lhs3_reg > rhs3_reg) && !holding_reg;
        sell = full3_reg && (lhs3_reg < rhs3_reg) && holding_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            holding_reg <= 1'b0;
            entry_reg   <= '0;
            profit_reg  <= '0;
        end else if (move3) begin
            if (buy) begin
                holding_reg <= 1'b1;
                entry_reg   <= price3_reg;
            end
            if (sell) begin
                holding_reg <= 1'b0;
                profit_reg  <= profit_next;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (move3) begin
            priority if (buy) begin
                act_reg    <= ACT_BUY;
                tprice_reg <= price3_reg;
            end else if (sell) begin
                act_reg    <= ACT_SELL;
                tprice_reg <= price3_reg;
            end else begin
                act_reg    <= ACT_NONE;
                tprice_reg <= '0;
            end
            oprofit_reg <= sell ? profit_next : profit_reg;
            ofull_reg   <= full3_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'({ofull_reg, oprofit_reg, tprice_reg, act_reg});

endmodule

[verif/moving_average_crossover_trader_tb.sv]
// Self-checking testbench for the moving average crossover trader: predicts each trade decision.
module moving_average_crossover_trader_tb;
    import macx_pkg::*;

    localparam int     CLK_HALF     = 5;
    localparam int     LATENCY      = 3;
    localparam int     CYCLE_LIMIT  = 1_500_000;
    localparam int     MAX_PRINTED  = 40;
    localparam int     GAP_MAX      = 8;
    localparam int     RING_DEPTH   = MAX_WINDOW_DEF;
    localparam int     REQ_TARGET   = 1700;
    localparam int     TP_LSB       = ACT_W;
    localparam int     PF_LSB       = ACT_W + PRICE_W;
    localparam int     WF_BIT       = PF_LSB + PROFIT_W;
    localparam longint PROFIT_MAX   = 64'sd140737488355327;
    localparam longint PROFIT_MIN   = -64'sd140737488355328;

    typedef enum int {
        RX_ALWAYS,
        RX_BURSTY,
        RX_SPARSE
    } rx_pattern_t;

    // One expected result, one field per output of the block.
    typedef struct {
        logic [ACT_W-1:0]    action;
        logic [PRICE_W-1:0]  trade_price;
        logic [PROFIT_W-1:0] total_profit;
        logic                windows_full;
    } trade_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [PRICE_W-1:0]     s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [ADDR_W-1:0]      paddr    = '0;
    logic [DATA_W-1:0]      pwdata   = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    // Predictor state: window settings, price ring, running sums and position.
    logic [WCFG_W-1:0]  short_cfg   = SHORT_RST;
    logic [WCFG_W-1:0]  long_cfg    = LONG_RST;
    logic [PRICE_W-1:0] price_ring [RING_DEPTH];
    int unsigned        ring_wr     = 0;
    int unsigned        ring_fill   = 0;
    longint unsigned    short_acc   = 0;
    longint unsigned    long_acc    = 0;
    bit                 in_position = 1'b0;
    logic [PRICE_W-1:0] entry_px    = '0;
    longint             profit_acc  = 0;

    trade_t             pending_trades [$];
    int unsigned        mismatch_count  = 0;
    int unsigned        results_checked = 0;
    int unsigned        requests_sent   = 0;
    int unsigned        cycle_count     = 0;

    // Stimulus and back-pressure controls.
    rx_pattern_t        rx_pattern    = RX_ALWAYS;
    bit                 rx_stalled    = 1'b0;
    int unsigned        rx_left       = 0;
    bit                 tx_gaps       = 1'b0;
    int unsigned        tx_burst_left = 0;
    logic [PRICE_W-1:0] walk_px       = 32'h0100_0000;
    int unsigned        walk_span     = 256;
    int unsigned        flat_left     = 0;

    moving_average_crossover_trader dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // A zero window counts as one price, an oversized one as the whole ring.
    function automatic int unsigned window_len(input logic [WCFG_W-1:0] w);
        if (w == 0) return 1;
        if (w > RING_DEPTH) return RING_DEPTH;
        return w;
    endfunction

    // Work out the decision for one price and advance the predictor state.
    function automatic trade_t predict_trade(input logic [PRICE_W-1:0] px);
        int unsigned     s_len;
        int unsigned     l_len;
        int unsigned     need;
        longint unsigned short_cmp;
        longint unsigned long_cmp;
        longint          step_pnl;
        trade_t          res;
        s_len = window_len(short_cfg);
        l_len = window_len(long_cfg);
        need  = (s_len > l_len) ? s_len : l_len;
        res.action      = ACT_NONE;
        res.trade_price = '0;

        // Drop the prices leaving each window before their ring slot is reused.
        if (ring_fill >= s_len)
            short_acc -= price_ring[(ring_wr + RING_DEPTH - s_len) % RING_DEPTH];
        if (ring_fill >= l_len)
            long_acc -= price_ring[(ring_wr + RING_DEPTH - l_len) % RING_DEPTH];
        short_acc += px;
        long_acc  += px;
        price_ring[ring_wr] = px;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        if (ring_fill < RING_DEPTH) ring_fill++;

        // Compare the averages by cross-multiplying with the other window length.
        res.windows_full = (ring_fill >= need);
        if (res.windows_full) begin
            short_cmp = short_acc * l_len;
            long_cmp  = long_acc * s_len;
            if (short_cmp > long_cmp && !in_position) begin
                in_position     = 1'b1;
                entry_px        = px;
                res.action      = ACT_BUY;
                res.trade_price = px;
            end else if (short_cmp < long_cmp && in_position) begin
                step_pnl = profit_acc + (longint'(px) - longint'(entry_px));
                if (step_pnl > PROFIT_MAX) step_pnl = PROFIT_MAX;
                if (step_pnl < PROFIT_MIN) step_pnl = PROFIT_MIN;
                profit_acc      = step_pnl;
                in_position     = 1'b0;
                res.action      = ACT_SELL;
                res.trade_price = px;
            end
        end
        res.total_profit = profit_acc[PROFIT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("MISMATCH result %0d: %s got 0x%0h want 0x%0h",
                     results_checked, what, got, want);
        mismatch_count++;
    endtask

    // Follow register writes, predict each accepted request and check each result.
    always @(posedge aclk) begin
        trade_t                 want;
        logic [OUT_TDATA_W-1:0] got;
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[ADDR_W-1] == REG_SHORT) short_cfg = pwdata[WCFG_W-1:0];
                else long_cfg = pwdata[WCFG_W-1:0];
                ring_fill = 0;
                short_acc = 0;
                long_acc  = 0;
            end
            if (s_tvalid && s_tready)
                pending_trades.insert(pending_trades.size(), predict_trade(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_trades.size() == 0) begin
                    report_mismatch("result with nothing pending", got[63:0], '0);
                end else begin
                    want = pending_trades.pop_front();
                    if (got[TP_LSB-1:0] !== want.action)
                        report_mismatch("action", got[TP_LSB-1:0], want.action);
                    if (got[TP_LSB +: PRICE_W] !== want.trade_price)
                        report_mismatch("trade_price", got[TP_LSB +: PRICE_W], want.trade_price);
                    if (got[PF_LSB +: PROFIT_W] !== want.total_profit)
                        report_mismatch("total_profit", got[PF_LSB +: PROFIT_W],
                                        want.total_profit);
                    if (got[WF_BIT] !== want.windows_full)
                        report_mismatch("windows_full", got[WF_BIT], want.windows_full);
                    if ((got >> OUT_FIELDS_W) !== '0)
                        report_mismatch("padding bits", 64'(got >> OUT_FIELDS_W), '0);
                end
                results_checked++;
            end
        end
    end

    // Receiver back-pressure: always ready, long stall bursts, or sparse random ready.
    always @(posedge aclk) begin
        case (rx_pattern)
            RX_ALWAYS: m_tready <= 1'b1;
            RX_SPARSE: m_tready <= ($urandom_range(0, 9) < 3);
            default: begin
                if (rx_left == 0) begin
                    rx_stalled = !rx_stalled;
                    rx_left = rx_stalled ? $urandom_range(1, 20) : $urandom_range(1, 12);
                end
                rx_left--;
                m_tready <= !rx_stalled;
            end
        endcase
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Send one price request, opening a random gap between bursts when enabled.
    task automatic push_price(input logic [PRICE_W-1:0] px);
        int unsigned gap;
        if (tx_burst_left == 0) begin
            gap = tx_gaps ? $urandom_range(0, GAP_MAX) : 0;
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            tx_burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        tx_burst_left--;
        requests_sent++;
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        tx_burst_left = 0;
        @(posedge aclk);
        while (pending_trades.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [WCFG_W-1:0] value);
        logic [DATA_W-1:0] junk;
        junk = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, {(ADDR_W-1){1'b0}}};
        pwdata  <= {junk[DATA_W-1:WCFG_W], value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Read a window register back and compare it with the predictor's copy.
    task automatic apb_read(input logic reg_sel);
        logic [WCFG_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_sel, {(ADDR_W-1){1'b0}}};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        want = (reg_sel == REG_SHORT) ? short_cfg : long_cfg;
        if (prdata[WCFG_W-1:0] !== want) report_mismatch("register read", prdata, want);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_windows(input logic [WCFG_W-1:0] s_w, input logic [WCFG_W-1:0] l_w);
        wait_idle();
        apb_write(REG_SHORT, s_w);
        apb_write(REG_LONG, l_w);
        apb_read(REG_SHORT);
        apb_read(REG_LONG);
    endtask

    // Mostly a random walk, with jumps, extreme prices and flat stretches mixed in.
    function automatic logic [PRICE_W-1:0] next_price();
        int unsigned pick;
        if (flat_left != 0) begin
            flat_left--;
            return walk_px;
        end
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            walk_px = walk_px + $urandom_range(0, 2 * walk_span) - walk_span;
        end else if (pick < 82) begin
            walk_px = $urandom();
        end else if (pick < 92) begin
            case ($urandom_range(0, 3))
                0: walk_px = '0;
                1: walk_px = '1;
                2: walk_px = 32'd1;
                default: walk_px = '1 - 32'd1;
            endcase
        end else if (pick < 95) begin
            flat_left = $urandom_range(1, 70);
        end
        return walk_px;
    endfunction

    task automatic pick_pressure();
        rx_pattern = rx_pattern_t'($urandom_range(0, 2));
        tx_gaps    = ($urandom_range(0, 3) != 0);
        walk_span  = 1 << $urandom_range(0, 20);
    endtask

    // Reset values, filling windows, a buy, a sell, equal averages and extreme prices.
    task automatic test_directed_basics();
        logic [PRICE_W-1:0] seq [19];
        seq = '{32'd0, 32'hFFFF_FFFF, 32'd5, 32'd5, 32'd5, 32'd5, 32'd5, 32'd5, 32'd9,
                32'd20, 32'd3, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'd0, 32'd0, 32'd0};
        rx_pattern = RX_BURSTY;
        tx_gaps    = 1'b1;
        apb_read(REG_SHORT);
        apb_read(REG_LONG);
        foreach (seq[i]) push_price(seq[i]);
    endtask

    // Window extremes: zero, one, the ring depth, beyond it, and either order.
    task automatic test_window_extremes();
        logic [WCFG_W-1:0] short_list [12];
        logic [WCFG_W-1:0] long_list [12];
        int unsigned       need;
        short_list = '{7'd0, 7'd1, 7'd64, 7'd1, 7'd64, 7'd65, 7'd2, 7'd0, 7'd127, 7'd1,
                       7'd2, 7'd3};
        long_list  = '{7'd127, 7'd1, 7'd64, 7'd64, 7'd1, 7'd2, 7'd65, 7'd0, 7'd127, 7'd2,
                       7'd1, 7'd3};
        foreach (short_list[i]) begin
            set_windows(short_list[i], long_list[i]);
            pick_pressure();
            need = window_len(short_list[i]);
            if (window_len(long_list[i]) > need) need = window_len(long_list[i]);
            repeat (need + $urandom_range(10, 40)) push_price(next_price());
        end
    endtask

    // Random window settings and price runs; the position survives each rewrite.
    task automatic test_random_trading();
        while (requests_sent < REQ_TARGET) begin
            if ($urandom_range(0, 4) != 0)
                set_windows(WCFG_W'($urandom_range(0, 8)), WCFG_W'($urandom_range(0, 12)));
            else
                set_windows(WCFG_W'($urandom_range(0, 127)), WCFG_W'($urandom_range(0, 127)));
            pick_pressure();
            repeat ($urandom_range(20, 120)) push_price(next_price());
        end
    endtask

    // Swing the profit total by the largest steps in both directions with windows of
    // one and two.
    task automatic test_profit_extremes();
        set_windows(7'd1, 7'd2);
        rx_pattern = RX_ALWAYS;
        tx_gaps    = 1'b0;
        // Buy just above the bottom, sell just below the top.
        repeat (20) begin
            push_price(32'd0);
            push_price(32'd1);
            push_price(32'hFFFF_FFFF);
            push_price(32'hFFFF_FFFE);
        end
        // Buy at the top, sell at the bottom.
        repeat (20) begin
            push_price(32'hFFFF_FFFF);
            push_price(32'd0);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_basics();
        test_window_extremes();
        test_random_trading();
        test_profit_extremes();
        wait_idle();
        if (pending_trades.size() != 0)
            report_mismatch("results never arrived", pending_trades.size(), '0);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/macx_pkg.sv
hdl/moving_average_crossover_trader.sv
verif/moving_average_crossover_trader_tb.sv
